[hdl/assert_macros.svh]
// Assertion helpers shared by the RTL; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: when ante holds, cons holds on the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons holds on the following edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[hdl/tsg_pkg.sv]
package tsg_pkg;

	localparam int COORD_BITS = 15;
	// Accumulators hold up to (edge height) * (column delta).
	localparam int ACC_W  = 2 * COORD_BITS + 2;
	localparam int MAG_W  = 2 * COORD_BITS;
	localparam int QUO_W  = COORD_BITS + 1;
	localparam int STEP_W = $clog2(COORD_BITS + 1);

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [COORD_BITS:0]   delta_t;
	typedef logic        [COORD_BITS-1:0] height_t;
	typedef logic signed [ACC_W-1:0]      acc_t;
	typedef logic signed [QUO_W-1:0]      quo_t;

endpackage

[hdl/tsg_div.sv]
// Bit-serial signed divider, quotient truncated toward zero.
// The quotient magnitude must fit in COORD_BITS bits, so only the low
// COORD_BITS dividend bits are shifted in, one per cycle.
module tsg_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  tsg_pkg::acc_t   num,
	input  tsg_pkg::height_t den,
	output logic            busy,
	output logic            done,
	output tsg_pkg::quo_t   quo
);
	import tsg_pkg::*;

	logic [COORD_BITS-1:0] rem_q;
	logic [COORD_BITS-1:0] low_q;
	logic [COORD_BITS-1:0] den_q;
	logic                  neg_q;
	logic                  zero_q;
	logic [STEP_W-1:0]     step_q;
	logic                  busy_q;
	logic                  done_q;

	acc_t                  num_abs;
	logic [MAG_W-1:0]      mag;
	logic [COORD_BITS:0]   trial;
	logic [COORD_BITS:0]   diff;
	logic                  fits;
	quo_t                  q_mag;

	always_comb begin
		num_abs = num[ACC_W-1] ? -num : num;
		mag     = num_abs[MAG_W-1:0];
		trial   = {rem_q, low_q[COORD_BITS-1]};
		diff    = trial - {1'b0, den_q};
		fits    = (trial >= {1'b0, den_q});
		q_mag   = $signed({1'b0, low_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(COORD_BITS);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= mag[MAG_W-1:COORD_BITS];
			low_q  <= mag[COORD_BITS-1:0];
			den_q  <= den;
			neg_q  <= num[ACC_W-1];
			zero_q <= (den == '0);
		end else if (busy_q) begin
			rem_q <= fits ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
			low_q <= {low_q[COORD_BITS-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = zero_q ? '0 : (neg_q ? -q_mag : q_mag);

endmodule

[hdl/triangle_span_generator_unit.sv]
// Triangle span generator: a start word loads a triangle, each request word yields one span.
// Request word (dropped with no triangle in progress): two COORD_BITS-step bit-serial
//   dividers run side by side; no word is taken until the span enters the output register.
// Start word: classified in the setup state; a flat one then loads its single span for output.
// Reset (arst_n low, asynchronous): idle, no triangle in progress, no span pending.
`include "assert_macros.svh"

module triangle_span_generator_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  logic             kind,
	input  tsg_pkg::coord_t  ax,
	input  tsg_pkg::coord_t  ay,
	input  tsg_pkg::coord_t  bx,
	input  tsg_pkg::coord_t  by,
	input  tsg_pkg::coord_t  cx,
	input  tsg_pkg::coord_t  cy,
	output logic             span_valid,
	input  logic             span_stall,
	output tsg_pkg::coord_t  row,
	output tsg_pkg::coord_t  span_start,
	output tsg_pkg::delta_t  span_end,
	output logic             last
);
	import tsg_pkg::*;

	// Sequencer codes.
	localparam logic [1:0] ST_IDLE  = 2'd0; // take a word
	localparam logic [1:0] ST_SETUP = 2'd1; // classify sorted triangle
	localparam logic [1:0] ST_DIV   = 2'd2; // edge divisions running
	localparam logic [1:0] ST_OUT   = 2'd3; // span ready for the output register

	logic [1:0] state_q;

	// Triangle state, vertices sorted by row (top first).
	coord_t col_q [3];
	coord_t rowv_q [3];
	coord_t cur_row_q;
	coord_t upper_last_q;
	acc_t   acc_short_q;
	acc_t   acc_long_q;
	logic   half_q;
	logic   busy_q;

	// Span waiting for the output register.
	coord_t edge_a_q;
	coord_t edge_b_q;
	coord_t pend_row_q;
	logic   fin_q;

	// Output register.
	logic   span_valid_q;
	coord_t row_q;
	coord_t span_start_q;
	delta_t span_end_q;
	logic   last_q;

	// Handshake.
	logic req_acc;
	logic div_start;
	logic out_load;

	// Sort network, three compare-and-swap stages; equal rows keep their order.
	coord_t sc [3];
	coord_t sr [3];
	coord_t tc;
	coord_t tr;

	// Divider hookup.
	height_t den_short;
	height_t den_long;
	quo_t    quo_s;
	quo_t    quo_l;
	logic    div_busy_s;
	logic    div_busy_l;
	logic    div_done_s;
	logic    div_done_l;

	// Edge arithmetic.
	delta_t h01;
	delta_t h12;
	delta_t h02;
	delta_t dx_short;
	delta_t dx_long;
	coord_t base_short;
	logic signed [COORD_BITS+1:0] sum_a;
	logic signed [COORD_BITS+1:0] sum_b;

	// Flat-triangle extent.
	coord_t col_min;
	coord_t col_max;

	// Output ordering.
	coord_t lo_edge;
	coord_t hi_edge;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;
	assign div_start = req_acc && kind && busy_q;
	assign out_load  = (state_q == ST_OUT) && (!span_valid_q || !span_stall);

	always_comb begin
		tc = '0;
		tr = '0;
		sc[0] = ax; sr[0] = ay;
		sc[1] = bx; sr[1] = by;
		sc[2] = cx; sr[2] = cy;
		if (sr[0] > sr[1]) begin
			tc = sc[0]; tr = sr[0];
			sc[0] = sc[1]; sr[0] = sr[1];
			sc[1] = tc; sr[1] = tr;
		end
		if (sr[1] > sr[2]) begin
			tc = sc[1]; tr = sr[1];
			sc[1] = sc[2]; sr[1] = sr[2];
			sc[2] = tc; sr[2] = tr;
		end
		if (sr[0] > sr[1]) begin
			tc = sc[0]; tr = sr[0];
			sc[0] = sc[1]; sr[0] = sr[1];
			sc[1] = tc; sr[1] = tr;
		end
	end

	always_comb begin
		h01 = delta_t'(rowv_q[1]) - delta_t'(rowv_q[0]);
		h12 = delta_t'(rowv_q[2]) - delta_t'(rowv_q[1]);
		h02 = delta_t'(rowv_q[2]) - delta_t'(rowv_q[0]);
		// Upper half walks top->mid, lower half walks mid->bottom.
		den_short  = half_q ? h12[COORD_BITS-1:0] : h01[COORD_BITS-1:0];
		den_long   = h02[COORD_BITS-1:0];
		dx_short   = half_q ? (delta_t'(col_q[2]) - delta_t'(col_q[1]))
		                    : (delta_t'(col_q[1]) - delta_t'(col_q[0]));
		dx_long    = delta_t'(col_q[2]) - delta_t'(col_q[0]);
		base_short = half_q ? col_q[1] : col_q[0];
		sum_a      = (COORD_BITS+2)'(base_short) + (COORD_BITS+2)'(quo_s);
		sum_b      = (COORD_BITS+2)'(col_q[0]) + (COORD_BITS+2)'(quo_l);

		col_min = col_q[0];
		col_max = col_q[0];
		if (col_q[1] < col_min) col_min = col_q[1];
		if (col_q[1] > col_max) col_max = col_q[1];
		if (col_q[2] < col_min) col_min = col_q[2];
		if (col_q[2] > col_max) col_max = col_q[2];

		if (edge_a_q > edge_b_q) begin
			lo_edge = edge_b_q;
			hi_edge = edge_a_q;
		end else begin
			lo_edge = edge_a_q;
			hi_edge = edge_b_q;
		end
	end

	tsg_div u_div_short (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_short_q),
		.den    (den_short),
		.busy   (div_busy_s),
		.done   (div_done_s),
		.quo    (quo_s)
	);

	tsg_div u_div_long (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_long_q),
		.den    (den_long),
		.busy   (div_busy_l),
		.done   (div_done_l),
		.quo    (quo_l)
	);

	// Sequencer and control flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			busy_q       <= 1'b0;
			half_q       <= 1'b0;
			span_valid_q <= 1'b0;
		end else begin
			// Raise valid when a span moves in; drop it once the word is taken.
			if (out_load) span_valid_q <= 1'b1;
			else if (span_valid_q && !span_stall) span_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					// A request with no triangle in progress is dropped.
					if (req_acc && !kind) state_q <= ST_SETUP;
					else if (div_start) state_q <= ST_DIV;
				end
				ST_SETUP: begin
					if (rowv_q[0] == rowv_q[2]) begin
						// Flat triangle: answer at once, no triangle left in progress.
						busy_q  <= 1'b0;
						half_q  <= 1'b0;
						state_q <= ST_OUT;
					end else begin
						busy_q  <= 1'b1;
						// Top and mid on one row: there is no upper half.
						half_q  <= (rowv_q[1] == rowv_q[0]);
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done_s) begin
						if (!half_q && cur_row_q == upper_last_q) half_q <= 1'b1;
						if (cur_row_q >= rowv_q[2]) busy_q <= 1'b0;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Triangle datapath.
	always_ff @(posedge clk) begin
		if (req_acc && !kind) begin
			for (int i = 0; i < 3; i++) begin
				col_q[i]  <= sc[i];
				rowv_q[i] <= sr[i];
			end
			cur_row_q   <= sr[0];
			acc_short_q <= '0;
			acc_long_q  <= '0;
		end
		if (state_q == ST_SETUP) begin
			upper_last_q <= (rowv_q[1] == rowv_q[2]) ? rowv_q[1]
			                                         : coord_t'(rowv_q[1] - coord_t'(1));
			// Flat triangle span; overwritten on every divided span.
			edge_a_q   <= col_min;
			edge_b_q   <= col_max;
			pend_row_q <= rowv_q[0];
			fin_q      <= 1'b1;
		end
		if (state_q == ST_DIV && div_done_s) begin
			edge_a_q   <= sum_a[COORD_BITS-1:0];
			edge_b_q   <= sum_b[COORD_BITS-1:0];
			pend_row_q <= cur_row_q;
			fin_q      <= (cur_row_q >= rowv_q[2]);
			cur_row_q  <= coord_t'(cur_row_q + coord_t'(1));
			acc_long_q <= acc_long_q + acc_t'(dx_long);
			// Leaving the upper half restarts the short edge at the mid vertex.
			if (!half_q && cur_row_q == upper_last_q) acc_short_q <= '0;
			else acc_short_q <= acc_short_q + acc_t'(dx_short);
		end
	end

	// Output register: order the edges, end column exclusive.
	always_ff @(posedge clk) begin
		if (out_load) begin
			row_q        <= pend_row_q;
			span_start_q <= lo_edge;
			span_end_q   <= delta_t'(hi_edge) + delta_t'(1);
			last_q       <= fin_q;
		end
	end

	assign span_valid = span_valid_q;
	assign row        = row_q;
	assign span_start = span_start_q;
	assign span_end   = span_end_q;
	assign last       = last_q;

	// Both edge dividers run the same number of steps and must finish together.
	`ASSERT_IMPLIES(a_div_lockstep, clk, arst_n, div_done_s || div_done_l, div_done_s && div_done_l)
	// Divider activity is confined to the division state.
	`ASSERT_IMPLIES(a_div_in_state, clk, arst_n, div_busy_s || div_busy_l, state_q == ST_DIV)
	// Handing over the final span leaves no triangle in progress.
	`ASSERT_NEXT(a_last_idles, clk, arst_n, out_load && fin_q, !busy_q)

endmodule
